[hw/rtl/api_frame_receiver_top_defines.svh]
// Assertion macros shared by the frame receiver RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef API_FRAME_RECEIVER_TOP_DEFINES_SVH
`define API_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/afr_pkg.sv]
// Package for the frame receiver: sizes, framing constants and shared types.
// No dependencies.
package afr_pkg;

	localparam int BUF_SIZE        = 256;
	localparam int MIN_FRAME_BYTES = 5;

	localparam int BYTE_W = 8;
	localparam int TIME_W = 32;
	localparam int TMO_W  = 16;
	localparam int LEN_W  = 16;
	localparam int CNT_W  = $clog2(BUF_SIZE + 1);
	// width for comparing the byte count against length + 4
	localparam int CMP_W  = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;

	localparam logic [BYTE_W-1:0] START_BYTE  = 8'h7E;
	localparam logic [TMO_W-1:0]  TMO_RESET   = 16'd100;
	localparam int                HDR_BYTES   = 4;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_DROP = 2'd1,
		ST_DONE = 2'd2
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] frame_type;
		logic [LEN_W-1:0]  frame_length;
	} res_t;

endpackage

[hw/rtl/afr_core.sv]
// Frame tracking state and the per-item update: timeout, restart, header
// capture, running sum and checksum check. Depends on afr_pkg.
`include "api_frame_receiver_top_defines.svh"

module afr_core
	import afr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [TIME_W-1:0] time_ms,
	input  logic [TMO_W-1:0]  timeout_ms,
	output res_t              res
);

	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] first_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] sum_q;
	logic [TIME_W-1:0] last_q;

	logic [TIME_W-1:0] gap;
	logic              drop;
	logic              restart;
	logic              match;
	logic [CNT_W-1:0]  cnt_a;
	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  held;
	logic [CNT_W-1:0]  cnt_n;
	logic [BYTE_W-1:0] first_n;
	logic [LEN_W-1:0]  len_n;
	logic [BYTE_W-1:0] type_n;
	logic [BYTE_W-1:0] sum_b;
	logic [BYTE_W-1:0] sum_n;
	logic [CMP_W-1:0]  frame_end;

	always_comb begin
		gap   = time_ms - last_q;
		drop  = 1'b0;
		cnt_a = cnt_q;
		if ((gap > TIME_W'(timeout_ms)) && (cnt_q != '0)) begin
			drop  = 1'b1;
			cnt_a = '0;
		end

		restart = (data_byte == START_BYTE) || (cnt_a >= CNT_W'(BUF_SIZE));
		if (restart && (cnt_a != '0))
			drop = 1'b1;
		pos = restart ? '0 : cnt_a;

		first_n = first_q;
		len_n   = len_q;
		type_n  = type_q;
		sum_b   = sum_q;
		if (pos == CNT_W'(0)) begin
			first_n = data_byte;
			sum_b   = '0;
		end else if (pos == CNT_W'(1)) begin
			len_n = {data_byte, len_q[BYTE_W-1:0]};
		end else if (pos == CNT_W'(2)) begin
			len_n = {len_q[LEN_W-1:BYTE_W], data_byte};
		end else if (pos == CNT_W'(3)) begin
			type_n = data_byte;
		end

		held      = pos + CNT_W'(1);
		frame_end = CMP_W'(len_n) + CMP_W'(HDR_BYTES);
		// checksum byte is 0xFF minus the data sum, i.e. its complement
		match = (first_n == START_BYTE) && (held >= CNT_W'(MIN_FRAME_BYTES)) &&
			(CMP_W'(held) == frame_end) && (~sum_b == data_byte);
		cnt_n = match ? '0 : held;
		sum_n = (pos >= CNT_W'(3)) ? sum_b + data_byte : sum_b;

		res.status       = match ? ST_DONE : (drop ? ST_DROP : ST_NONE);
		res.frame_type   = match ? type_n : '0;
		res.frame_length = match ? len_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= '0;
			len_q   <= '0;
			type_q  <= '0;
			sum_q   <= '0;
			last_q  <= '0;
		end else if (step_en) begin
			cnt_q   <= cnt_n;
			first_q <= first_n;
			len_q   <= len_n;
			type_q  <= type_n;
			sum_q   <= sum_n;
			last_q  <= time_ms;
		end
	end

	`AFR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(BUF_SIZE), "byte count beyond buffer")
	`AFR_ASSERT_NEXT(a_done_clears, step_en && (res.status == ST_DONE), cnt_q == '0,
		"count not cleared after completed frame")
	`AFR_ASSERT_NEXT(a_time_follows, step_en, last_q == $past(time_ms),
		"last timestamp not taken from item")

endmodule

[hw/rtl/api_frame_receiver_top.sv]
// Top level of the frame receiver: input register, timeout register,
// result register and handshakes. Depends on afr_pkg and afr_core.
`include "api_frame_receiver_top_defines.svh"

// An accepted item passes the input register and then the result register
// (two registers: input and result); a result-side stall holds it in between.
// Throughput: one item per cycle while the result side does not stall.
// Reset (arst_n low, asynchronous): pipeline empty, frame state zero,
// timeout register back to 100 ms.
module api_frame_receiver_top
	import afr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [TIME_W-1:0] time_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] frame_type,
	output logic [LEN_W-1:0]  frame_length,
	input  logic              cfg_wr_en,
	input  logic [TMO_W-1:0]  cfg_wr_data
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [TIME_W-1:0] time_s1;
	logic              out_valid_q;
	res_t              res_q;
	res_t              res;
	logic [TMO_W-1:0]  timeout_q;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TMO_RESET;
		else if (cfg_wr_en)
			timeout_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			time_s1 <= time_ms;
		end
		if (advance)
			res_q <= res;
	end

	afr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.data_byte  (byte_s1),
		.time_ms    (time_s1),
		.timeout_ms (timeout_q),
		.res        (res)
	);

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign frame_type   = res_q.frame_type;
	assign frame_length = res_q.frame_length;

	`AFR_ASSERT_NOW(a_no_overrun, in_valid && !in_stall,
		!(valid_s1 && out_valid_q && out_stall), "item accepted into a blocked stage")
	`AFR_ASSERT_NOW(a_done_len, out_valid_q && (res_q.status == ST_DONE),
		(LEN_W + 1)'(res_q.frame_length) + (LEN_W + 1)'(HDR_BYTES)
		>= (LEN_W + 1)'(MIN_FRAME_BYTES), "completed frame shorter than minimum")
	`AFR_ASSERT_NOW(a_fields_zero, out_valid_q && (res_q.status != ST_DONE),
		(res_q.frame_type == '0) && (res_q.frame_length == '0), "fields set without frame")

endmodule

[bench/afr_frame_checker.sv]
// Checker for the frame receiver: watches the byte and result channels,
// predicts each result from the bytes taken in, and compares.
// Depends on afr_pkg.
module afr_frame_checker
	import afr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [TIME_W-1:0] time_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [BYTE_W-1:0] frame_type,
	input  logic [LEN_W-1:0]  frame_length,
	input  logic              cfg_wr_en,
	input  logic [TMO_W-1:0]  cfg_wr_data,
	output int                fail_count,
	output int                pending
);

	// frame state as the block should hold it
	logic [TMO_W-1:0]  tmo_ms;
	logic [8:0]        rx_count;
	logic [BYTE_W-1:0] lead_byte;
	logic [LEN_W-1:0]  len_field;
	logic [BYTE_W-1:0] type_field;
	logic [BYTE_W-1:0] data_sum;
	logic [TIME_W-1:0] prev_time;

	res_t expected_results[$];
	int   errors = 0;
	int   outstanding = 0;

	assign fail_count = errors;
	assign pending    = outstanding;

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic [31:0] t, output res_t r);
		logic [8:0] pos;
		logic [7:0] want_sum;
		int         held;
		r.status       = ST_NONE;
		r.frame_type   = '0;
		r.frame_length = '0;
		// gap is taken modulo 2^32, so a wrapped timestamp is a short gap
		if (t - prev_time > 32'(tmo_ms) && rx_count != 0) begin
			r.status = ST_DROP;
			rx_count = '0;
		end
		prev_time = t;
		if (b == START_BYTE || rx_count >= BUF_SIZE) begin
			if (rx_count != 0)
				r.status = ST_DROP;
			rx_count = '0;
		end
		pos = rx_count;
		case (pos)
			0: begin
				lead_byte = b;
				data_sum  = '0;
			end
			1: len_field[15:8] = b;
			2: len_field[7:0]  = b;
			3: type_field      = b;
			default: ;
		endcase
		held     = int'(pos) + 1;
		rx_count = 9'(held);
		want_sum = 8'hFF - data_sum;
		if (lead_byte == START_BYTE && held >= MIN_FRAME_BYTES &&
				held == int'(len_field) + HDR_BYTES && want_sum == b) begin
			r.status       = ST_DONE;
			r.frame_type   = type_field;
			r.frame_length = len_field;
			rx_count       = '0;
		end
		// checksum byte joins the sum too; a failed check keeps collecting
		if (pos >= 3)
			data_sum = data_sum + b;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t fresh;
		if (!arst_n) begin
			tmo_ms     = TMO_RESET;
			rx_count   = '0;
			lead_byte  = '0;
			len_field  = '0;
			type_field = '0;
			data_sum   = '0;
			prev_time  = '0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_wr_en)
				tmo_ms = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result mismatch: expected none, got status %0h type %0h length %0h",
						$time, status, frame_type, frame_length);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report("status", want.status, status);
					if (frame_type !== want.frame_type)
						report("frame_type", want.frame_type, frame_type);
					if (frame_length !== want.frame_length)
						report("frame_length", want.frame_length, frame_length);
				end
			end
			if (in_valid && !in_stall) begin
				deframe_byte(data_byte, time_ms, fresh);
				expected_results.push_back(fresh);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the frame receiver bench: clock, reset, byte stimulus, result
// stalls and the verdict. Depends on afr_pkg, afr_frame_checker and the RTL.
module testbench
	import afr_pkg::*;
();

	localparam int LIMIT = 300000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic [TIME_W-1:0] time_ms;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [BYTE_W-1:0] frame_type;
	logic [LEN_W-1:0]  frame_length;
	logic              cfg_wr_en;
	logic [TMO_W-1:0]  cfg_wr_data;
	int                fail_count;
	int                pending;

	int                tmo_now = TMO_RESET;
	logic [TIME_W-1:0] now_ms;
	int                items_sent = 0;
	int                hold_requests = 0;
	int                cycles = 0;
	bit                tx_idle_on = 1'b1;
	bit                rx_idle_on = 1'b1;

	// opening bytes: shortest good frame, extreme data values, a bad checksum
	// dropped by the next start byte, a good frame, then a timeout mid-frame
	logic [7:0] opening [25] = '{
		8'h7E, 8'h00, 8'h01, 8'hAA, 8'h55,
		8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00,
		8'h7E, 8'h00, 8'h01, 8'h12, 8'h00,
		8'h7E, 8'h00, 8'h01, 8'h7D, 8'h82,
		8'h7E, 8'h00, 8'h05, 8'h7E
	};

	api_frame_receiver_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.frame_type  (frame_type),
		.frame_length(frame_length),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	afr_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.frame_type  (frame_type),
		.frame_length(frame_length),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [31:0] pick_gap(input bit late);
		if (late) begin
			case ($urandom_range(0, 3))
				0: return $urandom();
				1: return tmo_now + 1;
				default: return tmo_now + 1 + $urandom_range(0, 1000);
			endcase
		end
		return chance(12) ? tmo_now : $urandom_range(0, tmo_now);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit late);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		now_ms += pick_gap(late);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		time_ms   <= now_ms;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		items_sent++;
	endtask

	// start byte, length, data and checksum; a cut up to len stops after
	// that many data bytes with no checksum
	task automatic send_frame(input logic [15:0] len, input int cut, input bit bad_sum,
			input int late_pct);
		logic [7:0] d;
		logic [7:0] sum;
		sum = '0;
		send_byte(START_BYTE, chance(late_pct));
		send_byte(len[15:8], chance(late_pct));
		send_byte(len[7:0], chance(late_pct));
		for (int i = 0; i < int'(len) && i < cut; i++) begin
			d = 8'($urandom());
			if (d == START_BYTE)
				d = ~d;
			sum += d;
			send_byte(d, chance(late_pct));
		end
		if (cut > int'(len))
			send_byte((8'hFF - sum) ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00),
				chance(late_pct));
	endtask

	task automatic set_timeout(input logic [15:0] v);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tmo_now = v;
	endtask

	// result side: random stall per item, plus long hold-offs on request
	initial begin
		int stall_len;
		int served;
		int holds_done;
		served     = 0;
		holds_done = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (served % 40 == 0)
				rx_idle_on = chance(70);
			stall_len = rx_idle_on ? $urandom_range(0, 7) : 0;
			if (hold_requests > holds_done) begin
				stall_len = 200;
				holds_done++;
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			served++;
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [15:0] tmo_plan [4];
		logic [7:0]  d;
		int          phase_end;
		int          kind;
		int          len;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		time_ms     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timestamps wrap through zero during the opening bytes
		now_ms = 32'hFFFF_FFC0;
		foreach (opening[i])
			send_byte(opening[i], i == 23);

		tmo_plan = '{16'hFFFF, 16'h0000, 16'($urandom_range(1, 300)), TMO_RESET};
		foreach (tmo_plan[p]) begin
			set_timeout(tmo_plan[p]);
			now_ms = $urandom();
			if (p == 0) begin
				// overrun the buffer: restart comes with a byte other than start
				tx_idle_on = 1'b0;
				send_byte(START_BYTE, 1'b0);
				repeat (270) begin
					d = 8'($urandom());
					if (d == START_BYTE)
						d = 8'h00;
					send_byte(d, 1'b0);
				end
			end
			if (p == 0 || p == 2)
				hold_requests++;
			phase_end = items_sent + 180;
			while (items_sent < phase_end) begin
				tx_idle_on = chance(75);
				kind = $urandom_range(0, 99);
				if (kind < 72) begin
					case ($urandom_range(0, 19))
						0: len = 0;
						1: len = $urandom_range(13, 80);
						default: len = $urandom_range(1, 12);
					endcase
					if ($urandom_range(0, 199) == 0)
						len = $urandom_range(240, 251);
					send_frame(16'(len), 1 << 20, chance(10), 3);
				end else if (kind < 87) begin
					repeat ($urandom_range(1, 8))
						send_byte(8'($urandom()), chance(15));
				end else begin
					send_frame(chance(50) ? 16'($urandom()) : 16'($urandom_range(0, 12)),
						$urandom_range(0, 6), 1'b0, 10);
				end
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
